### rtl/tpbag_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpbag_pkg
// shared types and constants of the tiled page border address generator
// ----------------------------------------------------------------------------
package tpbag_pkg;

  // fixed field widths
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 15;
  localparam int BORDER_W    = 5;
  localparam int BORDER_MAX  = 16;
  localparam int TILE_CNT_W  = 28;
  localparam int SRC_W       = 30;
  localparam int OFF_W       = 25;
  localparam int STREAM_W    = 40;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 128;
  localparam int OUT_USER_W  = 2;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_MODE    = 3'd5;

  // depth modes
  localparam logic [1:0] DEPTH_8BIT  = 2'd0;
  localparam logic [1:0] DEPTH_16BIT = 2'd1;

  // element size as a left shift
  localparam logic [1:0] SHIFT_1B = 2'd0;
  localparam logic [1:0] SHIFT_2B = 2'd1;
  localparam logic [1:0] SHIFT_4B = 2'd2;

  typedef enum logic {
    CMD_ADVANCE,
    CMD_START
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GEOM,
    ST_MUL,
    ST_SUM,
    ST_SCALE,
    ST_OUT
  } back_state_e;

  typedef struct packed {
    logic                  last_of_all;
    logic                  last_in_tile;
    logic                  valid_res;
    logic [STREAM_W-1:0]   stream_byte_address;
    logic [OFF_W-1:0]      page_byte_offset;
    logic [SRC_W-1:0]      source_index;
    logic [TILE_CNT_W-1:0] tile_index;
  } result_t;

  typedef struct packed {
    logic valid;
    cmd_e cmd;
  } queue_head_t;

endpackage

### rtl/tiled_page_border_address_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiled_page_border_address_generator
// element addresses for border-padded tiles of an image, clamp to edge
// ----------------------------------------------------------------------------
// the back-end sequencer runs pop, geometry, multiply, sum, scale and output
//   load for each transaction; output load waits for tready, and no new
//   transaction is popped before the last one is loaded out
// the 2-deep front queue takes input while the back works, until it is full
// reset: registers to their defaults, walk idle, no clearing pass
// ----------------------------------------------------------------------------
module tiled_page_border_address_generator #(
  parameter int MAX_DIM_BITS  = 14,
  parameter int MAX_TILE_BITS = 10,
  parameter int MAX_CHANNELS  = 4
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input stream
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // [0] start_req, [7:1] zero
  input  logic [tpbag_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,
  // output stream
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // [27:0] tile_index, [57:28] source_index, [82:58] page_byte_offset,
  // [122:83] stream_byte_address, [127:123] zero
  output logic [tpbag_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  // last_in_tile
  output logic                                  m_axis_tlast_o,
  // [0] valid_res, [1] last_of_all
  output logic [tpbag_pkg::OUT_USER_W-1:0]      m_axis_tuser_o,
  // configuration write port
  input  logic                                  cfg_we_i,
  input  logic [tpbag_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tpbag_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import tpbag_pkg::*;

  localparam int DIM_W    = MAX_DIM_BITS + 1;
  localparam int TILE_W   = MAX_TILE_BITS + 1;
  localparam int CNT_W    = $clog2(MAX_CHANNELS + 1);
  localparam int DIM_MAX  = 1 << MAX_DIM_BITS;
  localparam int TILE_MAX = 1 << MAX_TILE_BITS;
  localparam int TILE_RST = (256 < TILE_MAX) ? 256 : TILE_MAX;

  // registers hold the effective (saturated) values
  logic [DIM_W-1:0]    img_w_q, img_h_q;
  logic [TILE_W-1:0]   tile_q;
  logic [BORDER_W-1:0] border_q;
  logic [CNT_W-1:0]    chan_q;
  logic [1:0]          shift_q;
  logic                cfg_hit;

  queue_head_t head;
  logic        pop;
  result_t     m_data;

  // zero counts as one, large values saturate
  function automatic logic [DIM_W-1:0] sat_dim(input logic [CFG_DATA_W-1:0] v);
    if (v == '0) begin
      return DIM_W'(1);
    end else if (32'(v) > DIM_MAX) begin
      return DIM_W'(DIM_MAX);
    end
    return DIM_W'(v);
  endfunction

  function automatic logic [TILE_W-1:0] sat_tile(input logic [CFG_DATA_W-1:0] v);
    if (v[10:0] == '0) begin
      return TILE_W'(1);
    end else if (32'(v[10:0]) > TILE_MAX) begin
      return TILE_W'(TILE_MAX);
    end
    return TILE_W'(v[10:0]);
  endfunction

  function automatic logic [CNT_W-1:0] sat_chan(input logic [CFG_DATA_W-1:0] v);
    if (v[2:0] == '0) begin
      return CNT_W'(1);
    end else if (32'(v[2:0]) > MAX_CHANNELS) begin
      return CNT_W'(MAX_CHANNELS);
    end
    return CNT_W'(v[2:0]);
  endfunction

  // register decode, unknown indexes do nothing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q  <= DIM_W'(1);
      img_h_q  <= DIM_W'(1);
      tile_q   <= TILE_W'(TILE_RST);
      border_q <= '0;
      chan_q   <= CNT_W'(1);
      shift_q  <= SHIFT_1B;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_WIDTH:   img_w_q <= sat_dim(cfg_wdata_i);
        CFG_IMAGE_HEIGHT:  img_h_q <= sat_dim(cfg_wdata_i[14:0]);
        CFG_TILE_SIZE:     tile_q  <= sat_tile(cfg_wdata_i);
        CFG_BORDER_WIDTH: begin
          border_q <= (32'(cfg_wdata_i[4:0]) > BORDER_MAX) ? BORDER_W'(BORDER_MAX)
                                                           : cfg_wdata_i[4:0];
        end
        CFG_CHANNEL_COUNT: chan_q  <= sat_chan(cfg_wdata_i);
        CFG_DEPTH_MODE: begin
          unique case (cfg_wdata_i[1:0])
            DEPTH_8BIT:  shift_q <= SHIFT_1B;
            DEPTH_16BIT: shift_q <= SHIFT_2B;
            default:     shift_q <= SHIFT_4B;  // float, and the spare code
          endcase
        end
        default: ;
      endcase
    end
  end

  // any write to a known register ends the walk
  assign cfg_hit = cfg_we_i && (cfg_idx_i == CFG_IMAGE_WIDTH  ||
                                cfg_idx_i == CFG_IMAGE_HEIGHT ||
                                cfg_idx_i == CFG_TILE_SIZE    ||
                                cfg_idx_i == CFG_BORDER_WIDTH ||
                                cfg_idx_i == CFG_CHANNEL_COUNT ||
                                cfg_idx_i == CFG_DEPTH_MODE);

  // front: accept and classify start / advance into a short queue
  tpbag_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .head_o          (head),
    .pop_i           (pop)
  );

  // back: walker state, address arithmetic and output register
  tpbag_back #(
    .MAX_DIM_BITS  (MAX_DIM_BITS),
    .MAX_TILE_BITS (MAX_TILE_BITS),
    .MAX_CHANNELS  (MAX_CHANNELS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .pop_o     (pop),
    .cfg_wr_i  (cfg_hit),
    .img_w_i   (img_w_q),
    .img_h_i   (img_h_q),
    .tile_i    (tile_q),
    .border_i  (border_q),
    .chan_i    (chan_q),
    .shift_i   (shift_q),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_data_o  (m_data)
  );

  // pack the result transaction
  assign m_axis_tdata_o = OUT_DATA_W'({m_data.stream_byte_address,
                                       m_data.page_byte_offset,
                                       m_data.source_index,
                                       m_data.tile_index});
  assign m_axis_tlast_o = m_data.last_in_tile;
  assign m_axis_tuser_o = {m_data.last_of_all, m_data.valid_res};

endmodule

### rtl/tpbag_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpbag_front
// accepts input transactions, classifies them and queues the commands
// ----------------------------------------------------------------------------
module tpbag_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [0] start_req, rest zero
  input  logic [tpbag_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  output tpbag_pkg::queue_head_t               head_o,
  input  logic                                 pop_i
);
  import tpbag_pkg::*;

  cmd_e              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push;
  logic              pop;
  cmd_e              cmd_in;

  assign s_axis_tready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign pop             = pop_i && (cnt_q != '0);
  assign cmd_in          = s_axis_tdata_i[0] ? CMD_START : CMD_ADVANCE;

  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

### rtl/tpbag_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpbag_back
// page walker and address pipeline with the output register
// ----------------------------------------------------------------------------
module tpbag_back #(
  parameter int MAX_DIM_BITS  = 14,
  parameter int MAX_TILE_BITS = 10,
  parameter int MAX_CHANNELS  = 4,
  localparam int DIM_W  = MAX_DIM_BITS + 1,
  localparam int TILE_W = MAX_TILE_BITS + 1,
  localparam int CNT_W  = $clog2(MAX_CHANNELS + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tpbag_pkg::queue_head_t           head_i,
  output logic                             pop_o,
  input  logic                             cfg_wr_i,
  input  logic [DIM_W-1:0]                 img_w_i,
  input  logic [DIM_W-1:0]                 img_h_i,
  input  logic [TILE_W-1:0]                tile_i,
  input  logic [tpbag_pkg::BORDER_W-1:0]   border_i,
  input  logic [CNT_W-1:0]                 chan_i,
  input  logic [1:0]                       shift_i,
  output logic                             m_valid_o,
  input  logic                             m_ready_i,
  output tpbag_pkg::result_t               m_data_o
);
  import tpbag_pkg::*;

  localparam int POS_W   = MAX_DIM_BITS;
  localparam int PAGE_W  = (TILE_W > 6 ? TILE_W : 6) + 1;
  localparam int CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int XW      = (POS_W > PAGE_W ? POS_W : PAGE_W) + 2;
  localparam int SUM_W   = (POS_W > TILE_W ? POS_W : TILE_W) + 1;
  localparam int CW      = (DIM_W > TILE_W ? DIM_W : TILE_W);
  localparam int PROD_W  = POS_W + DIM_W;
  localparam int PP_W    = 2 * PAGE_W;
  localparam int EL_W    = PP_W + CNT_W;
  localparam int BYTES_W = EL_W + 2;

  back_state_e state_q, state_d;

  // walker state
  logic [POS_W-1:0]      ox_q, ox_d, oy_q, oy_d;
  logic [PAGE_W-1:0]     col_q, col_d, row_q, row_d;
  logic [CH_W-1:0]       ch_q, ch_d;
  logic [TILE_CNT_W-1:0] tile_cnt_q, tile_cnt_d;
  logic [STREAM_W-1:0]   base_q, base_d;
  logic                  active_q, active_d;
  logic                  zero_q, zero_d;

  // pipeline payload
  logic [PAGE_W-1:0]  pw_q, ph_q;
  logic [POS_W-1:0]   sx_q, sy_q;
  logic               xend_q, yend_q;
  logic               lt_q, la_q;
  logic [PROD_W-1:0]  sy_w_q;
  logic [PP_W-1:0]    row_pw_q, pp_q, b_q;
  logic [SRC_W-1:0]   a_q, src_q;
  logic [EL_W-1:0]    ppc_q, offe_q;
  logic [BYTES_W-1:0] page_bytes_q;
  logic               m_valid_q, m_valid_d;
  result_t            m_data_q, m_data_d;

  // combinational geometry
  logic [SUM_W-1:0]       ox_sum, oy_sum;
  logic                   x_end, y_end;
  logic [CW-1:0]          rest_x, rest_y, tw, th;
  logic [PAGE_W-1:0]      pw, ph;
  logic signed [XW-1:0]   vx, vy;
  logic [POS_W-1:0]       sx, sy;
  logic                   pop;
  logic                   load_out;
  logic                   ch_wrap, col_wrap, row_wrap;
  logic [BYTES_W-1:0]     off_full;

  assign ox_sum = SUM_W'(ox_q) + SUM_W'(tile_i);
  assign oy_sum = SUM_W'(oy_q) + SUM_W'(tile_i);
  assign x_end  = (ox_sum >= SUM_W'(img_w_i));
  assign y_end  = (oy_sum >= SUM_W'(img_h_i));

  always_comb begin
    rest_x = CW'(img_w_i) - CW'(ox_q);
    rest_y = CW'(img_h_i) - CW'(oy_q);
    tw     = (rest_x < CW'(tile_i)) ? rest_x : CW'(tile_i);
    th     = (rest_y < CW'(tile_i)) ? rest_y : CW'(tile_i);
    pw     = PAGE_W'(tw) + PAGE_W'(border_i) + PAGE_W'(border_i);
    ph     = PAGE_W'(th) + PAGE_W'(border_i) + PAGE_W'(border_i);
    // clamp to edge
    vx = $signed(XW'(ox_q)) + $signed(XW'(col_q)) - $signed(XW'(border_i));
    vy = $signed(XW'(oy_q)) + $signed(XW'(row_q)) - $signed(XW'(border_i));
    if (vx[XW-1]) begin
      sx = '0;
    end else if ($unsigned(vx) >= XW'(img_w_i)) begin
      sx = POS_W'(img_w_i - DIM_W'(1));
    end else begin
      sx = POS_W'($unsigned(vx));
    end
    if (vy[XW-1]) begin
      sy = '0;
    end else if ($unsigned(vy) >= XW'(img_h_i)) begin
      sy = POS_W'(img_h_i - DIM_W'(1));
    end else begin
      sy = POS_W'($unsigned(vy));
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (head_i.valid) state_d = ST_GEOM;
      ST_GEOM:  state_d = ST_MUL;
      ST_MUL:   state_d = ST_SUM;
      ST_SUM:   state_d = ST_SCALE;
      ST_SCALE: state_d = ST_OUT;
      ST_OUT:   if (!m_valid_q || m_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop      = (state_q == ST_IDLE) && head_i.valid;
    load_out = (state_q == ST_OUT) && (!m_valid_q || m_ready_i);
  end

  assign pop_o = pop;

  // walker advance, uses the page size of the element last produced
  assign ch_wrap  = (CNT_W'(ch_q) + CNT_W'(1)) >= chan_i;
  assign col_wrap = (col_q + PAGE_W'(1)) >= pw_q;
  assign row_wrap = (row_q + PAGE_W'(1)) >= ph_q;

  always_comb begin
    ox_d       = ox_q;
    oy_d       = oy_q;
    col_d      = col_q;
    row_d      = row_q;
    ch_d       = ch_q;
    tile_cnt_d = tile_cnt_q;
    base_d     = base_q;
    active_d   = active_q;
    zero_d     = zero_q;
    if (pop) begin
      if (head_i.cmd == CMD_START) begin
        ox_d       = '0;
        oy_d       = '0;
        col_d      = '0;
        row_d      = '0;
        ch_d       = '0;
        tile_cnt_d = '0;
        base_d     = '0;
        active_d   = 1'b1;
      end else if (active_q) begin
        if (!ch_wrap) begin
          ch_d = ch_q + CH_W'(1);
        end else begin
          ch_d = '0;
          if (!col_wrap) begin
            col_d = col_q + PAGE_W'(1);
          end else begin
            col_d = '0;
            if (!row_wrap) begin
              row_d = row_q + PAGE_W'(1);
            end else begin
              // next tile
              row_d      = '0;
              base_d     = base_q + STREAM_W'(page_bytes_q);
              tile_cnt_d = tile_cnt_q + TILE_CNT_W'(1);
              if (!x_end) begin
                ox_d = POS_W'(ox_sum);
              end else begin
                ox_d = '0;
                if (!y_end) begin
                  oy_d = POS_W'(oy_sum);
                end else begin
                  // walk ended
                  oy_d       = '0;
                  tile_cnt_d = '0;
                  base_d     = '0;
                  active_d   = 1'b0;
                end
              end
            end
          end
        end
      end
      zero_d = !active_d;
    end
    if (cfg_wr_i) begin
      active_d = 1'b0;
    end
  end

  // output register
  always_comb begin
    off_full  = BYTES_W'(offe_q) << shift_i;
    m_data_d  = m_data_q;
    m_valid_d = m_valid_q;
    if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
    if (load_out) begin
      m_valid_d = 1'b1;
      if (zero_q) begin
        m_data_d = '0;
      end else begin
        m_data_d.valid_res           = 1'b1;
        m_data_d.tile_index          = tile_cnt_q;
        m_data_d.source_index        = src_q;
        m_data_d.page_byte_offset    = OFF_W'(off_full);
        m_data_d.stream_byte_address = base_q + STREAM_W'(off_full);
        m_data_d.last_in_tile        = lt_q;
        m_data_d.last_of_all         = la_q;
      end
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ox_q       <= '0;
      oy_q       <= '0;
      col_q      <= '0;
      row_q      <= '0;
      ch_q       <= '0;
      tile_cnt_q <= '0;
      base_q     <= '0;
      active_q   <= 1'b0;
      zero_q     <= 1'b1;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      ox_q       <= ox_d;
      oy_q       <= oy_d;
      col_q      <= col_d;
      row_q      <= row_d;
      ch_q       <= ch_d;
      tile_cnt_q <= tile_cnt_d;
      base_q     <= base_d;
      active_q   <= active_d;
      zero_q     <= zero_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    if (state_q == ST_GEOM) begin
      pw_q   <= pw;
      ph_q   <= ph;
      sx_q   <= sx;
      sy_q   <= sy;
      xend_q <= x_end;
      yend_q <= y_end;
    end
    if (state_q == ST_MUL) begin
      sy_w_q   <= PROD_W'(sy_q) * PROD_W'(img_w_i);
      row_pw_q <= PP_W'(row_q) * PP_W'(pw_q);
      pp_q     <= PP_W'(pw_q) * PP_W'(ph_q);
      lt_q     <= (CNT_W'(ch_q) == (chan_i - CNT_W'(1))) &&
                  (col_q == pw_q - PAGE_W'(1)) && (row_q == ph_q - PAGE_W'(1));
    end
    if (state_q == ST_SUM) begin
      a_q   <= SRC_W'(sx_q) + SRC_W'(sy_w_q);
      b_q   <= PP_W'(col_q) + row_pw_q;
      ppc_q <= EL_W'(pp_q) * EL_W'(chan_i);
      la_q  <= lt_q && xend_q && yend_q;
    end
    if (state_q == ST_SCALE) begin
      src_q        <= a_q * SRC_W'(chan_i) + SRC_W'(ch_q);
      offe_q       <= EL_W'(b_q) * EL_W'(chan_i) + EL_W'(ch_q);
      page_bytes_q <= BYTES_W'(ppc_q) << shift_i;
    end
  end

endmodule
